@@ rtl/core/tsg_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsg_pkg
// Shared widths and types for the triangle shape gradient pipeline.
// ----------------------------------------------------------------------------
package tsg_pkg;

    localparam int COORD_BITS     = 16;
    localparam int FRAC_BITS      = 32;
    localparam int NODE_ID_BITS   = 20;
    localparam int AREA_OUT_BITS  = 33;
    localparam int GRAD_OUT_BITS  = 48;

    localparam int DIFF_BITS  = COORD_BITS + 1;
    localparam int MAG_BITS   = COORD_BITS;
    localparam int PROD_BITS  = 2 * DIFF_BITS;
    localparam int DET_BITS   = PROD_BITS + 1;
    localparam int AREA_BITS  = 2 * COORD_BITS + 1;
    localparam int QUOT_BITS  = MAG_BITS + FRAC_BITS;
    localparam int NUM_LANES  = 6;

    typedef logic [NODE_ID_BITS-1:0] t_id;

    typedef struct packed {
        logic [AREA_BITS-1:0] area;
        logic                 degenerate;
        logic                 swapped;
        t_id                  id2;
        t_id                  id3;
        logic                 final_flag;
        logic [NUM_LANES-1:0] neg;
    } t_side;

endpackage

@@ rtl/core/triangle_shape_gradients_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// triangle_shape_gradients_unit
// Linear triangle shape function gradients with orientation fix.
// ----------------------------------------------------------------------------
// The pipeline has three setup stages, one divider stage per quotient bit,
// and an output register.
// Throughput is one request per cycle; busy is always low.
// Reset clears only the valid bits; data registers are not reset.
// The result strobe o_done is high for one cycle per request.
module triangle_shape_gradients_unit
    import tsg_pkg::*;
(
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [NODE_ID_BITS-1:0]      i_first_id,
    input  logic [NODE_ID_BITS-1:0]      i_second_id,
    input  logic [NODE_ID_BITS-1:0]      i_third_id,
    input  logic signed [COORD_BITS-1:0] i_x1,
    input  logic signed [COORD_BITS-1:0] i_y1,
    input  logic signed [COORD_BITS-1:0] i_x2,
    input  logic signed [COORD_BITS-1:0] i_y2,
    input  logic signed [COORD_BITS-1:0] i_x3,
    input  logic signed [COORD_BITS-1:0] i_y3,
    input  logic                         i_final_element,
    output logic                         o_done,
    output logic [AREA_OUT_BITS-1:0]     o_double_area,
    output logic                         o_degenerate,
    output logic                         o_swapped,
    output logic [NODE_ID_BITS-1:0]      o_ccw_second_id,
    output logic [NODE_ID_BITS-1:0]      o_ccw_third_id,
    output logic signed [GRAD_OUT_BITS-1:0] o_grad1_x,
    output logic signed [GRAD_OUT_BITS-1:0] o_grad1_y,
    output logic signed [GRAD_OUT_BITS-1:0] o_grad2_x,
    output logic signed [GRAD_OUT_BITS-1:0] o_grad2_y,
    output logic signed [GRAD_OUT_BITS-1:0] o_grad3_x,
    output logic signed [GRAD_OUT_BITS-1:0] o_grad3_y,
    output logic                         o_final_result
);

    localparam int EXT_BITS = QUOT_BITS + GRAD_OUT_BITS + 1;
    localparam int AEXT_BITS = AREA_BITS + AREA_OUT_BITS;

    assign busy = 1'b0;

    // Stage 1: coordinate differences.
    logic                        r_v1;
    t_id                         r_id2_1, r_id3_1;
    logic                        r_fin_1;
    logic signed [DIFF_BITS-1:0] r_dif [NUM_LANES];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else begin
            r_v1 <= start;
        end
        r_id2_1 <= i_second_id;
        r_id3_1 <= i_third_id;
        r_fin_1 <= i_final_element;
        r_dif[0] <= DIFF_BITS'(i_y2) - DIFF_BITS'(i_y3);
        r_dif[1] <= DIFF_BITS'(i_x3) - DIFF_BITS'(i_x2);
        r_dif[2] <= DIFF_BITS'(i_y3) - DIFF_BITS'(i_y1);
        r_dif[3] <= DIFF_BITS'(i_x1) - DIFF_BITS'(i_x3);
        r_dif[4] <= DIFF_BITS'(i_y1) - DIFF_BITS'(i_y2);
        r_dif[5] <= DIFF_BITS'(i_x2) - DIFF_BITS'(i_x1);
    end

    // Stage 2: cross products and magnitudes.
    logic                        r_v2;
    t_id                         r_id2_2, r_id3_2;
    logic                        r_fin_2;
    logic signed [PROD_BITS-1:0] r_pa, r_pb;
    logic [MAG_BITS-1:0]         r_mag [NUM_LANES];
    logic [NUM_LANES-1:0]        r_sgn;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else begin
            r_v2 <= r_v1;
        end
        r_id2_2 <= r_id2_1;
        r_id3_2 <= r_id3_1;
        r_fin_2 <= r_fin_1;
        r_pa <= PROD_BITS'(r_dif[5]) * PROD_BITS'(r_dif[2]);
        r_pb <= PROD_BITS'(r_dif[3]) * PROD_BITS'(r_dif[4]);
        for (int k = 0; k < NUM_LANES; k++) begin
            r_sgn[k] <= r_dif[k][DIFF_BITS-1];
            r_mag[k] <= r_dif[k][DIFF_BITS-1] ? MAG_BITS'(-r_dif[k])
                                                : MAG_BITS'(r_dif[k]);
        end
    end

    // Stage 3: orientation, area and lane selection.
    logic signed [DET_BITS-1:0] n_det;
    logic                       n_swap;
    logic                       r_v3;
    t_side                      r_side3;
    logic [MAG_BITS-1:0]        r_lmag [NUM_LANES];

    assign n_det  = DET_BITS'(r_pa) - DET_BITS'(r_pb);
    assign n_swap = n_det[DET_BITS-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
        end else begin
            r_v3 <= r_v2;
        end
        r_side3.area       <= n_swap ? AREA_BITS'(-n_det) : AREA_BITS'(n_det);
        r_side3.degenerate <= (n_det == '0);
        r_side3.swapped    <= n_swap;
        r_side3.id2        <= n_swap ? r_id3_2 : r_id2_2;
        r_side3.id3        <= n_swap ? r_id2_2 : r_id3_2;
        r_side3.final_flag <= r_fin_2;
        if (n_swap) begin
            r_side3.neg <= ~{r_sgn[3], r_sgn[2], r_sgn[5], r_sgn[4], r_sgn[1], r_sgn[0]};
            r_lmag[0] <= r_mag[0];
            r_lmag[1] <= r_mag[1];
            r_lmag[2] <= r_mag[4];
            r_lmag[3] <= r_mag[5];
            r_lmag[4] <= r_mag[2];
            r_lmag[5] <= r_mag[3];
        end else begin
            r_side3.neg <= r_sgn;
            for (int k = 0; k < NUM_LANES; k++) begin
                r_lmag[k] <= r_mag[k];
            end
        end
    end

    // Divider lanes.
    logic [QUOT_BITS-1:0] n_quot [NUM_LANES];

    genvar l;
    generate
        for (l = 0; l < NUM_LANES; l++) begin : g_lane
            tsg_div_pipe u_div (
                .i_clk  (i_clk),
                .i_mag  (r_lmag[l]),
                .i_den  (r_side3.area),
                .o_quot (n_quot[l])
            );
        end
    endgenerate

    // Side information travels alongside the divider stages.
    logic  r_vq [QUOT_BITS+1];
    t_side r_sq [QUOT_BITS+1];

    always_comb begin
        r_vq[0] = r_v3;
        r_sq[0] = r_side3;
    end

    genvar s;
    generate
        for (s = 0; s < QUOT_BITS; s++) begin : g_side
            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_vq[s+1] <= 1'b0;
                end else begin
                    r_vq[s+1] <= r_vq[s];
                end
                r_sq[s+1] <= r_sq[s];
            end
        end
    endgenerate

    // Saturation and output register.
    localparam logic [EXT_BITS-1:0] LIM = EXT_BITS'((64'd1 << (GRAD_OUT_BITS - 1)) - 64'd1);

    logic [GRAD_OUT_BITS-1:0] n_grad [NUM_LANES];
    t_side                    n_last;

    assign n_last = r_sq[QUOT_BITS];

    always_comb begin
        logic [EXT_BITS-1:0] q;
        for (int k = 0; k < NUM_LANES; k++) begin
            q = EXT_BITS'(n_quot[k]);
            if (n_last.degenerate) begin
                n_grad[k] = '0;
            end else if (n_last.neg[k]) begin
                if (q > LIM + EXT_BITS'(1)) begin
                    q = LIM + EXT_BITS'(1);
                end
                n_grad[k] = GRAD_OUT_BITS'(-q);
            end else begin
                if (q > LIM) begin
                    q = LIM;
                end
                n_grad[k] = GRAD_OUT_BITS'(q);
            end
        end
    end

    logic [AEXT_BITS-1:0] n_area_ext;
    localparam logic [AEXT_BITS-1:0] AREA_MAX = AEXT_BITS'({AREA_OUT_BITS{1'b1}});
    assign n_area_ext = AEXT_BITS'(n_last.area);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_done <= 1'b0;
        end else begin
            o_done <= r_vq[QUOT_BITS];
        end
        o_double_area   <= (n_area_ext > AREA_MAX) ? {AREA_OUT_BITS{1'b1}}
                                                   : AREA_OUT_BITS'(n_area_ext);
        o_degenerate    <= n_last.degenerate;
        o_swapped       <= n_last.swapped;
        o_ccw_second_id <= n_last.id2;
        o_ccw_third_id  <= n_last.id3;
        o_final_result  <= n_last.final_flag;
        o_grad1_x <= n_grad[0];
        o_grad1_y <= n_grad[1];
        o_grad2_x <= n_grad[2];
        o_grad2_y <= n_grad[3];
        o_grad3_x <= n_grad[4];
        o_grad3_y <= n_grad[5];
    end

endmodule

@@ rtl/core/tsg_div_pipe.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsg_div_pipe
// Pipelined restoring divider, one quotient bit per stage, for
// (magnitude << FRAC_BITS) / area.
// ----------------------------------------------------------------------------
module tsg_div_pipe
    import tsg_pkg::*;
(
    input  logic                 i_clk,
    input  logic [MAG_BITS-1:0]  i_mag,
    input  logic [AREA_BITS-1:0] i_den,
    output logic [QUOT_BITS-1:0] o_quot
);

    logic [AREA_BITS-1:0] r_rem [QUOT_BITS+1];
    logic [QUOT_BITS-1:0] r_nq  [QUOT_BITS+1];
    logic [AREA_BITS-1:0] r_den [QUOT_BITS+1];

    always_comb begin
        r_rem[0] = '0;
        r_nq[0]  = {i_mag, {FRAC_BITS{1'b0}}};
        r_den[0] = i_den;
    end

    genvar g;
    generate
        for (g = 0; g < QUOT_BITS; g++) begin : g_stage
            logic [AREA_BITS:0] n_trial;
            logic               n_ge;
            always_comb begin
                n_trial = {r_rem[g], r_nq[g][QUOT_BITS-1]};
                n_ge    = (n_trial >= {1'b0, r_den[g]});
            end
            always_ff @(posedge i_clk) begin
                if (n_ge) begin
                    r_rem[g+1] <= AREA_BITS'(n_trial - {1'b0, r_den[g]});
                end else begin
                    r_rem[g+1] <= n_trial[AREA_BITS-1:0];
                end
                r_nq[g+1]  <= {r_nq[g][QUOT_BITS-2:0], n_ge};
                r_den[g+1] <= r_den[g];
            end
        end
    endgenerate

    assign o_quot = r_nq[QUOT_BITS];

endmodule
